### design/ppcc_pkg.sv
// Shared types, op codes and constants for the pulse period count converter.
package ppcc_pkg;

    localparam int NUM_W = 68;
    localparam int DEN_W = 41;
    localparam int CNT_W = 7;

    localparam logic [19:0]      US_PER_S  = 20'd1000000;
    localparam logic [47:0]      MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [55:0]      MAX56 = 56'hFF_FFFF_FFFF_FFFF;

    // 1e6 * 2^16 = 15625 * 2^22: filter clocks = ((filter * clock) >> 22) / 15625,
    // the divide done as a multiply by ceil(2^44 / 15625) and a shift by 44
    localparam logic [31:0] FC_RECIP = 32'd1125899907;
    localparam logic [29:0] FC_SAT   = 30'd1024000000;   // 15625 * 65536

    // Configuration register indexes
    localparam logic [2:0] REG_CLOCK  = 3'd0;
    localparam logic [2:0] REG_AVG    = 3'd1;
    localparam logic [2:0] REG_FILTER = 3'd2;
    localparam logic [2:0] REG_MINF   = 3'd3;
    localparam logic [2:0] REG_INVERT = 3'd4;
    localparam logic [2:0] REG_SCALE  = 3'd5;
    localparam logic [2:0] REG_OFFSET = 3'd6;

    // Datapath op sequence
    localparam logic [3:0] OP_DEN  = 4'd0;   // den = clock * averages
    localparam logic [3:0] OP_PMUL = 4'd1;   // period * 1e6
    localparam logic [3:0] OP_PDIV = 4'd2;   // mean period
    localparam logic [3:0] OP_WMUL = 4'd3;   // width * 1e6
    localparam logic [3:0] OP_WDIV = 4'd4;   // mean width
    localparam logic [3:0] OP_FMUL = 4'd5;   // filter * clock
    localparam logic [3:0] OP_FDIV = 4'd6;   // filter clocks, reciprocal multiply
    localparam logic [3:0] OP_LDIV = 4'd7;   // limit word
    localparam logic [3:0] OP_DMUL = 4'd8;   // width * |scale|
    localparam logic [3:0] OP_DDIV = 4'd9;   // duty
    localparam logic [3:0] OP_QDIV = 4'd10;  // frequency

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       div_start;
        logic       capture;
        logic       out_load;
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic p_zero;
    } t_status;

    function automatic logic op_is_mul(input logic [3:0] op);
        return (op == OP_DEN) || (op == OP_PMUL) || (op == OP_WMUL) ||
               (op == OP_FMUL) || (op == OP_FDIV) || (op == OP_DMUL);
    endfunction

endpackage

### design/ppcc_div.sv
// Restoring divider, one quotient bit per cycle.
module ppcc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ppcc_pkg::NUM_W-1:0]  i_num,
    input  logic [ppcc_pkg::DEN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [ppcc_pkg::NUM_W-1:0]  o_quo,
    output logic                        o_rem_nz
);
    import ppcc_pkg::*;

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   n_sh;
    logic             n_ge;

    assign n_sh = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign n_ge = n_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], n_ge};
            r_rem <= n_ge ? (n_sh - {1'b0, r_den}) : n_sh;
        end
    end

    assign o_done   = r_done;
    assign o_quo    = r_quo;
    assign o_rem_nz = |r_rem;
endmodule

### design/ppcc_dp.sv
// Datapath: config registers, shared multiplier, divider, result registers.
module ppcc_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    input  logic [31:0]           i_status_word,
    input  logic [31:0]           i_period_count,
    input  logic [31:0]           i_width_count,
    input  ppcc_pkg::t_cmd        i_cmd,
    output ppcc_pkg::t_status     o_status,
    output logic [47:0]           o_mean_period,
    output logic [47:0]           o_mean_width,
    output logic signed [47:0]    o_duty_cycle,
    output logic [55:0]           o_frequency_hz,
    output logic                  o_valid_res,
    output logic                  o_input_level,
    output logic [31:0]           o_mode_word,
    output logic [31:0]           o_limit_word
);
    import ppcc_pkg::*;

    // config
    logic [28:0]        r_clock;
    logic [15:0]        r_avg;
    logic [31:0]        r_filter;
    logic [31:0]        r_minf;
    logic               r_invert;
    logic signed [31:0] r_scale;
    logic signed [31:0] r_offset;

    // item and work registers
    logic [1:0]       r_flags;
    logic [31:0]      r_p;
    logic [31:0]      r_w;
    logic [DEN_W-1:0] r_den;
    logic [63:0]      r_mul;
    logic [47:0]      r_period;
    logic [47:0]      r_width;
    logic [15:0]      r_fc;
    logic [31:0]      r_lim;
    logic signed [47:0] r_held_duty;
    logic [55:0]      r_held_freq;

    logic [28:0]      n_c;
    logic [11:0]      n_a;
    logic [31:0]      n_smag;
    logic [31:0]      n_ma, n_mb;
    logic [63:0]      n_prod;
    logic             n_fc_sat;
    logic [NUM_W-1:0] n_num;
    logic [DEN_W-1:0] n_dv;
    logic             div_done, rem_nz;
    logic [NUM_W-1:0] quo;
    logic [50:0]      n_qc;
    logic signed [52:0] n_dsum;
    logic [34:0]      n_c40;
    logic             n_lover;

    assign n_c = (r_clock == '0) ? 29'd1 : r_clock;
    assign n_a = (r_avg == '0) ? 12'd1 : ((r_avg > 16'hFFF) ? 12'hFFF : r_avg[11:0]);
    assign n_smag = r_scale[31] ? (32'd0 - r_scale) : r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock  <= 29'd100000000;
            r_avg    <= 16'd1;
            r_filter <= 32'd65536;
            r_minf   <= 32'd65536;
            r_invert <= 1'b0;
            r_scale  <= 32'sd6553600;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CLOCK:  r_clock  <= i_cfg_data[28:0];
                REG_AVG:    r_avg    <= i_cfg_data[15:0];
                REG_FILTER: r_filter <= i_cfg_data;
                REG_MINF:   r_minf   <= i_cfg_data;
                REG_INVERT: r_invert <= i_cfg_data[0];
                REG_SCALE:  r_scale  <= i_cfg_data;
                REG_OFFSET: r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        case (i_cmd.op)
            OP_DEN:  begin n_ma = {3'd0, n_c};  n_mb = {20'd0, n_a}; end
            OP_PMUL: begin n_ma = r_p;          n_mb = {12'd0, US_PER_S}; end
            OP_WMUL: begin n_ma = r_w;          n_mb = {12'd0, US_PER_S}; end
            OP_FMUL: begin n_ma = r_filter;     n_mb = {3'd0, n_c}; end
            OP_FDIV: begin n_ma = {2'd0, r_mul[51:22]}; n_mb = FC_RECIP; end
            OP_DMUL: begin n_ma = r_w;          n_mb = n_smag; end
            default: begin n_ma = r_w;          n_mb = n_smag; end
        endcase
    end

    assign n_prod = n_ma * n_mb;
    // filter clocks saturate once (filter * clock) >> 22 reaches 15625 * 65536
    assign n_fc_sat = (|r_mul[63:52]) || (r_mul[51:22] >= FC_SAT);

    // divider operand select
    always_comb begin
        case (i_cmd.op)
            OP_PDIV, OP_WDIV: begin n_num = {r_mul[51:0], 16'd0}; n_dv = r_den; end
            OP_LDIV:          begin n_num = {11'd0, r_den, 16'd0}; n_dv = {9'd0, r_minf}; end
            OP_DDIV:          begin n_num = {4'd0, r_mul};         n_dv = {9'd0, r_p}; end
            default:          begin n_num = {11'd0, r_den, 16'd0}; n_dv = {9'd0, r_p}; end
        endcase
    end

    ppcc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_num    (n_num),
        .i_den    (n_dv),
        .o_done   (div_done),
        .o_quo    (quo),
        .o_rem_nz (rem_nz)
    );

    // duty clamp to 2^50, sign, offset
    assign n_qc = ((|quo[67:51]) || (quo[50] && (|quo[49:0]))) ? {1'b1, 50'd0} : quo[50:0];
    assign n_dsum = (r_scale[31] ? -$signed({2'b00, n_qc}) : $signed({2'b00, n_qc}))
                    + 53'(r_offset);
    assign n_c40 = 35'(n_c) * 35'd40;
    assign n_lover = (r_minf == '0) || (|quo[67:32]) || ((&quo[31:0]) && rem_nz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_duty <= '0;
            r_held_freq <= '0;
        end else if (i_cmd.capture) begin
            if (i_cmd.op == OP_DDIV) begin
                if (n_dsum > 53'sh7FFF_FFFF_FFFF)
                    r_held_duty <= 48'sh7FFF_FFFF_FFFF;
                else if (n_dsum < -53'sh8000_0000_0000)
                    r_held_duty <= 48'sh8000_0000_0000;
                else
                    r_held_duty <= n_dsum[47:0];
            end
            if (i_cmd.op == OP_QDIV)
                r_held_freq <= (|quo[67:56]) ? MAX56 : quo[55:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_flags <= i_status_word[2:1];
            r_p     <= i_period_count;
            r_w     <= i_width_count;
        end
        if (i_cmd.mul) begin
            if (i_cmd.op == OP_DEN)
                r_den <= n_prod[DEN_W-1:0];
            else if (i_cmd.op == OP_FDIV)
                r_fc  <= n_fc_sat ? 16'hFFFF : n_prod[59:44];
            else
                r_mul <= n_prod;
        end
        if (i_cmd.capture) begin
            case (i_cmd.op)
                OP_PDIV: r_period <= (|quo[67:48]) ? MAX48 : quo[47:0];
                OP_WDIV: r_width  <= (|quo[67:48]) ? MAX48 : quo[47:0];
                OP_LDIV: r_lim    <= n_lover ? ((|n_c40[34:32]) ? 32'hFFFF_FFFF : n_c40[31:0])
                                             : quo[31:0];
                default: ;
            endcase
        end
        if (i_cmd.out_load) begin
            o_mean_period  <= r_period;
            o_mean_width   <= r_width;
            o_duty_cycle   <= r_held_duty;
            o_frequency_hz <= r_held_freq;
            o_valid_res    <= r_flags[0];
            o_input_level  <= r_flags[1];
            o_mode_word    <= {r_fc, n_a - 12'd1, 3'd0, r_invert};
            o_limit_word   <= r_lim;
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.p_zero   = (r_p == '0);
endmodule

### design/ppcc_ctrl.sv
// Controller: steps the datapath through its op sequence and runs the handshakes.
module ppcc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    input  ppcc_pkg::t_status  i_status,
    output ppcc_pkg::t_cmd     o_cmd
);
    import ppcc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    logic [3:0] r_op, n_op;
    logic       r_ovalid, n_ovalid;
    logic       n_last;

    assign n_last = (r_op == OP_QDIV) || ((r_op == OP_LDIV) && i_status.p_zero);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.op = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_op    = OP_DEN;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (op_is_mul(r_op)) begin
                    o_cmd.mul = 1'b1;
                    n_op = r_op + 4'd1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.capture = 1'b1;
                    if (n_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_op    = r_op + 4'd1;
                        n_state = S_RUN;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_ovalid = o_cmd.out_load | (r_ovalid & ~i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_DEN;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
endmodule

### design/pulse_period_count_converter_top.sv
// Top level of the pulse period count converter.
// Converts one period-unit snapshot (status, summed period and width counts) into
// period and width in microseconds (16 fraction bits), duty cycle, frequency, flags,
// mode word and limit word. One item is worked at a time: a single 32x32 multiplier
// and one shared restoring divider (68 quotient bits, one per cycle) do all the math;
// filter clocks come from a multiply by a fixed reciprocal. Each division is started,
// runs its 68 quotient bits and is captured. With a zero period count an item runs
// 5 multiplies and 3 divisions; otherwise 6 multiplies and 5 divisions. The result
// sits in an output register, so the next item is taken while it waits; a finished
// result stalls only while the one before is still unread.
// Duty and frequency hold their last values when period count is zero.
// Config writes go straight to the registers and are meant for an idle block.
module pulse_period_count_converter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_status_word,
    input  logic [31:0]        i_period_count,
    input  logic [31:0]        i_width_count,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [47:0]        o_mean_period,
    output logic [47:0]        o_mean_width,
    output logic signed [47:0] o_duty_cycle,
    output logic [55:0]        o_frequency_hz,
    output logic               o_valid_res,
    output logic               o_input_level,
    output logic [31:0]        o_mode_word,
    output logic [31:0]        o_limit_word
);
    import ppcc_pkg::*;

    t_cmd    cmd;
    t_status status;

    ppcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ppcc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_status_word  (i_status_word),
        .i_period_count (i_period_count),
        .i_width_count  (i_width_count),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_mean_period  (o_mean_period),
        .o_mean_width   (o_mean_width),
        .o_duty_cycle   (o_duty_cycle),
        .o_frequency_hz (o_frequency_hz),
        .o_valid_res    (o_valid_res),
        .o_input_level  (o_input_level),
        .o_mode_word    (o_mode_word),
        .o_limit_word   (o_limit_word)
    );

    // an accepted item keeps the block busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after accepting an item");

    // results load only when the output register is free or being drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || i_ready))
        else $error("pending result overwritten");

    // divider never restarted while the controller is idle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !o_ready)
        else $error("divider started while idle");
endmodule
